// ===== rtl/rcm_pkg.sv =====
package rcm_pkg;

  localparam int COUNT_BITS   = 60;
  localparam int VALUE_BITS   = 60;
  localparam int MOD_BITS     = 31;
  localparam int PROD_BITS    = 2 * MOD_BITS;
  localparam int VALUE_DIGITS = 18;
  localparam int DIG_BITS     = $clog2(VALUE_DIGITS + 1);

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    OP_VMOD,
    OP_SMOD,
    OP_ACC,
    OP_SQ_B,
    OP_SQ_A,
    OP_FIN
  } op_t;

  typedef struct packed {
    logic accept;
    logic dig_inc;
    logic shift_cnt;
    logic load_out;
    logic start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic m_small;
    logic dig_more;
    logic cnt_zero;
    logic cnt_lsb;
    logic cnt_last;
  } sts_t;

  function automatic logic [VALUE_BITS-1:0] pow10(input logic [DIG_BITS-1:0] d);
    logic [VALUE_BITS-1:0] p;
    case (d)
      5'd0:    p = 60'd1;
      5'd1:    p = 60'd10;
      5'd2:    p = 60'd100;
      5'd3:    p = 60'd1000;
      5'd4:    p = 60'd10000;
      5'd5:    p = 60'd100000;
      5'd6:    p = 60'd1000000;
      5'd7:    p = 60'd10000000;
      5'd8:    p = 60'd100000000;
      5'd9:    p = 60'd1000000000;
      5'd10:   p = 60'd10000000000;
      5'd11:   p = 60'd100000000000;
      5'd12:   p = 60'd1000000000000;
      5'd13:   p = 60'd10000000000000;
      5'd14:   p = 60'd100000000000000;
      5'd15:   p = 60'd1000000000000000;
      5'd16:   p = 60'd10000000000000000;
      5'd17:   p = 60'd100000000000000000;
      5'd18:   p = 60'd1000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/rcm_mulmod.sv =====
module rcm_mulmod (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             reduce,
  input  logic [rcm_pkg::MOD_BITS-1:0]     x,
  input  logic [rcm_pkg::MOD_BITS-1:0]     y,
  input  logic [rcm_pkg::MOD_BITS-1:0]     z,
  input  logic [rcm_pkg::MOD_BITS-1:0]     m,
  input  logic [rcm_pkg::VALUE_BITS-1:0]   wide,
  output logic                             done,
  output logic [rcm_pkg::MOD_BITS-1:0]     res
);
  import rcm_pkg::*;

  localparam int STEPS   = 4;
  localparam int SH_BITS = 64;
  localparam int CNT_W   = 4;
  localparam int HALF    = SH_BITS / 2;
  localparam logic [CNT_W-1:0] CYC_WIDE = CNT_W'(SH_BITS / STEPS - 1);
  localparam logic [CNT_W-1:0] CYC_MUL  = CNT_W'(HALF / STEPS - 1);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_RED  = 4'b0100,
    U_ADD  = 4'b1000
  } ustate_t;

  ustate_t                state_r, state_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic [MOD_BITS-1:0]    r_r, r_nxt;
  logic [MOD_BITS-1:0]    z_r, z_nxt;
  logic [SH_BITS-1:0]     sh_r, sh_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [MOD_BITS-1:0]    red_val;
  logic [MOD_BITS:0]      sum;

  always_comb begin
    logic [MOD_BITS-1:0] t;
    logic [MOD_BITS:0]   w;
    t = r_r;
    for (int k = 0; k < STEPS; k++) begin
      w = {t, sh_r[SH_BITS-1-k]};
      if (w >= {1'b0, m}) begin
        w = w - {1'b0, m};
      end
      t = w[MOD_BITS-1:0];
    end
    red_val = t;
  end

  assign sum  = {1'b0, r_r} + {1'b0, z_r};
  assign res  = (sum >= {1'b0, m}) ? MOD_BITS'(sum - {1'b0, m}) : sum[MOD_BITS-1:0];
  assign done = (state_r == U_ADD);

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    r_nxt     = r_r;
    z_nxt     = z_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      U_IDLE: begin
        if (start) begin
          if (reduce) begin
            r_nxt     = '0;
            z_nxt     = '0;
            sh_nxt    = SH_BITS'(wide);
            cnt_nxt   = CYC_WIDE;
            state_nxt = U_RED;
          end else begin
            prod_nxt  = PROD_BITS'(x) * PROD_BITS'(y);
            z_nxt     = z;
            state_nxt = U_MUL;
          end
        end
      end
      U_MUL: begin
        r_nxt     = MOD_BITS'(prod_r[PROD_BITS-1:HALF]);
        sh_nxt    = {prod_r[HALF-1:0], {(SH_BITS-HALF){1'b0}}};
        cnt_nxt   = CYC_MUL;
        state_nxt = U_RED;
      end
      U_RED: begin
        r_nxt   = red_val;
        sh_nxt  = sh_r << STEPS;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = U_ADD;
        end
      end
      U_ADD: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    r_r    <= r_nxt;
    z_r    <= z_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
  end

  a_res_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (done && (m[MOD_BITS-1:1] != '0)) |-> (res < m))
    else $error("reduced result not below the modulus");

  a_partial_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_RED) |-> (r_r < m))
    else $error("partial remainder not below the modulus");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("completion lasted more than one cycle");

endmodule

// ===== rtl/rcm_datapath.sv =====
module rcm_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [rcm_pkg::MOD_BITS-1:0]     cfg_data,
  input  logic [rcm_pkg::COUNT_BITS-1:0]   in_repeat_count,
  input  logic [rcm_pkg::VALUE_BITS-1:0]   in_value,
  input  rcm_pkg::cmd_t                    cmd,
  output rcm_pkg::sts_t                    sts,
  output logic [rcm_pkg::MOD_BITS-1:0]     out_result
);
  import rcm_pkg::*;

  logic [MOD_BITS-1:0]   modulus_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [DIG_BITS-1:0]   dig_r;
  logic [MOD_BITS-1:0]   vm_r;
  logic [MOD_BITS-1:0]   ba_r;
  logic [MOD_BITS-1:0]   bb_r;
  logic [MOD_BITS-1:0]   ab_r;
  logic [MOD_BITS-1:0]   res_r;

  logic                  u_reduce;
  logic [MOD_BITS-1:0]   u_x, u_y, u_z, u_res;
  logic [VALUE_BITS-1:0] u_wide;
  logic                  u_done;

  always_comb begin
    u_reduce = 1'b0;
    u_x      = ab_r;
    u_y      = ba_r;
    u_z      = '0;
    u_wide   = val_r;
    case (cmd.op)
      OP_VMOD: begin
        u_reduce = 1'b1;
      end
      OP_SMOD: begin
        u_reduce = 1'b1;
        u_wide   = pow10(dig_r);
      end
      OP_ACC: begin
        u_z = bb_r;
      end
      OP_SQ_B: begin
        u_x = bb_r;
        u_z = bb_r;
      end
      OP_SQ_A: begin
        u_x = ba_r;
      end
      OP_FIN: begin
        u_y = vm_r;
      end
      default: begin
        u_reduce = 1'b0;
      end
    endcase
  end

  rcm_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .reduce (u_reduce),
    .x      (u_x),
    .y      (u_y),
    .z      (u_z),
    .m      (modulus_r),
    .wide   (u_wide),
    .done   (u_done),
    .res    (u_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_valid) begin
      modulus_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_r <= in_repeat_count;
      val_r <= in_value;
      dig_r <= '0;
      ab_r  <= '0;
      bb_r  <= MOD_BITS'(1);
    end else begin
      if (cmd.dig_inc) begin
        dig_r <= dig_r + DIG_BITS'(1);
      end
      if (cmd.shift_cnt) begin
        cnt_r <= cnt_r >> 1;
      end
      if (u_done) begin
        case (cmd.op)
          OP_VMOD: vm_r <= u_res;
          OP_SMOD: ba_r <= u_res;
          OP_ACC:  ab_r <= u_res;
          OP_SQ_B: bb_r <= u_res;
          OP_SQ_A: ba_r <= u_res;
          OP_FIN:  ab_r <= u_res;
          default: ab_r <= ab_r;
        endcase
      end
    end
    if (cmd.load_out) begin
      res_r <= ab_r;
    end
  end

  assign sts.done     = u_done;
  assign sts.m_small  = (modulus_r[MOD_BITS-1:1] == '0);
  assign sts.dig_more = (dig_r != DIG_BITS'(VALUE_DIGITS)) && (val_r >= pow10(dig_r));
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_lsb  = cnt_r[0];
  assign sts.cnt_last = (cnt_r[COUNT_BITS-1:1] == '0);

  assign out_result = res_r;

endmodule

// ===== rtl/rcm_ctrl.sv =====
module rcm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  rcm_pkg::sts_t sts,
  output rcm_pkg::cmd_t cmd
);
  import rcm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DIG  = 10'b00_0000_0010,
    S_VMOD = 10'b00_0000_0100,
    S_SMOD = 10'b00_0000_1000,
    S_LOOP = 10'b00_0001_0000,
    S_ACC  = 10'b00_0010_0000,
    S_SQB  = 10'b00_0100_0000,
    S_SQA  = 10'b00_1000_0000,
    S_FIN  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.op        = OP_VMOD;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.m_small ? S_OUT : S_DIG;
        end
      end
      S_DIG: begin
        if (sts.dig_more) begin
          cmd.dig_inc = 1'b1;
        end else begin
          state_nxt = S_VMOD;
        end
      end
      S_VMOD: begin
        cmd.op    = OP_VMOD;
        cmd.start = 1'b1;
        if (sts.done) begin
          state_nxt = S_SMOD;
        end
      end
      S_SMOD: begin
        cmd.op    = OP_SMOD;
        cmd.start = 1'b1;
        if (sts.done) begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.cnt_zero) begin
          state_nxt = S_FIN;
        end else if (sts.cnt_lsb) begin
          state_nxt = S_ACC;
        end else begin
          cmd.shift_cnt = 1'b1;
          state_nxt     = S_SQB;
        end
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        cmd.start = 1'b1;
        if (sts.done) begin
          cmd.shift_cnt = 1'b1;
          state_nxt     = sts.cnt_last ? S_FIN : S_SQB;
        end
      end
      S_SQB: begin
        cmd.op    = OP_SQ_B;
        cmd.start = 1'b1;
        if (sts.done) begin
          state_nxt = S_SQA;
        end
      end
      S_SQA: begin
        cmd.op    = OP_SQ_A;
        cmd.start = 1'b1;
        if (sts.done) begin
          state_nxt = S_LOOP;
        end
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        cmd.start = 1'b1;
        if (sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == S_VMOD || state_r == S_SMOD || state_r == S_ACC ||
                  state_r == S_SQB || state_r == S_SQA || state_r == S_FIN))
    else $error("arithmetic unit finished outside an operation state");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before its transfer");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && sts.done) |=> (state_r == S_OUT && !in_tready))
    else $error("final product did not lead to the output state");

endmodule

// ===== rtl/repeated_concat_mod_top.sv =====
// A modulus below 2 skips the arithmetic and goes straight to the output state.
// Each modular product runs on the shared multiply-and-reduce unit (four bits per cycle), as do
// the two 60-bit reductions. One item is in work at a time: no new input is taken until the
// result of the last one has been loaded into the output register.
// Synchronous active-low reset clears control state and loads the modulus with 1000000007.
module repeated_concat_mod_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // [59:0] repeat_count, [119:60] value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // [30:0] result, [31] zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);
  import rcm_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [MOD_BITS-1:0] result;

  rcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rcm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_repeat_count (in_tdata[COUNT_BITS-1:0]),
    .in_value        (in_tdata[COUNT_BITS+VALUE_BITS-1:COUNT_BITS]),
    .cmd             (cmd),
    .sts             (sts),
    .out_result      (result)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, result};

endmodule
